FILE: design/vrsu_pkg.sv
// vrsu_pkg: shared types, constants and ROM functions for vertex_rotate_scale_unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrsu_pkg;

    typedef enum logic [2:0] {
        ACT_ROT_X   = 3'd0,
        ACT_ROT_Y   = 3'd1,
        ACT_ROT_Z   = 3'd2,
        ACT_ROT_YX  = 3'd3,
        ACT_ROT_YXZ = 3'd4,
        ACT_SCALE   = 3'd5,
        ACT_PASS6   = 3'd6,
        ACT_PASS7   = 3'd7
    } action_t;

    // one rotation step for a coordinate pair, passed between stages
    typedef struct packed {
        logic       en;
        logic [7:0] ang;
    } rot_ctl_t;

    // first half of the sine ROM, amplitude 63
    function automatic logic [7:0] sine_half(input logic [6:0] a);
        logic [7:0] v;
        case (a)
            7'd0: v = 8'd0;    7'd1: v = 8'd2;    7'd2: v = 8'd3;    7'd3: v = 8'd5;
            7'd4: v = 8'd6;    7'd5: v = 8'd8;    7'd6: v = 8'd9;    7'd7: v = 8'd11;
            7'd8: v = 8'd12;   7'd9: v = 8'd14;   7'd10: v = 8'd15;  7'd11: v = 8'd17;
            7'd12: v = 8'd18;  7'd13: v = 8'd20;  7'd14: v = 8'd21;  7'd15: v = 8'd23;
            7'd16: v = 8'd24;  7'd17: v = 8'd26;  7'd18: v = 8'd27;  7'd19: v = 8'd28;
            7'd20: v = 8'd30;  7'd21: v = 8'd31;  7'd22: v = 8'd32;  7'd23: v = 8'd34;
            7'd24: v = 8'd35;  7'd25: v = 8'd36;  7'd26: v = 8'd38;  7'd27: v = 8'd39;
            7'd28: v = 8'd40;  7'd29: v = 8'd41;  7'd30: v = 8'd42;  7'd31: v = 8'd43;
            7'd32: v = 8'd45;  7'd33: v = 8'd46;  7'd34: v = 8'd47;  7'd35: v = 8'd48;
            7'd36: v = 8'd49;  7'd37: v = 8'd50;  7'd38: v = 8'd51;  7'd39: v = 8'd52;
            7'd40: v = 8'd52;  7'd41: v = 8'd53;  7'd42: v = 8'd54;  7'd43: v = 8'd55;
            7'd44: v = 8'd56;  7'd45: v = 8'd56;  7'd46: v = 8'd57;  7'd47: v = 8'd58;
            7'd48: v = 8'd58;  7'd49: v = 8'd59;  7'd50: v = 8'd59;  7'd51: v = 8'd60;
            7'd52: v = 8'd60;  7'd53: v = 8'd61;  7'd54: v = 8'd61;  7'd55: v = 8'd61;
            7'd56: v = 8'd62;  7'd57: v = 8'd62;  7'd58: v = 8'd62;  7'd59: v = 8'd63;
            7'd60: v = 8'd63;  7'd61: v = 8'd63;  7'd62: v = 8'd63;  7'd63: v = 8'd63;
            7'd64: v = 8'd63;  7'd65: v = 8'd63;  7'd66: v = 8'd63;  7'd67: v = 8'd63;
            7'd68: v = 8'd63;  7'd69: v = 8'd63;  7'd70: v = 8'd62;  7'd71: v = 8'd62;
            7'd72: v = 8'd62;  7'd73: v = 8'd61;  7'd74: v = 8'd61;  7'd75: v = 8'd61;
            7'd76: v = 8'd60;  7'd77: v = 8'd60;  7'd78: v = 8'd59;  7'd79: v = 8'd59;
            7'd80: v = 8'd58;  7'd81: v = 8'd58;  7'd82: v = 8'd57;  7'd83: v = 8'd56;
            7'd84: v = 8'd56;  7'd85: v = 8'd55;  7'd86: v = 8'd54;  7'd87: v = 8'd53;
            7'd88: v = 8'd52;  7'd89: v = 8'd52;  7'd90: v = 8'd51;  7'd91: v = 8'd50;
            7'd92: v = 8'd49;  7'd93: v = 8'd48;  7'd94: v = 8'd47;  7'd95: v = 8'd46;
            7'd96: v = 8'd45;  7'd97: v = 8'd43;  7'd98: v = 8'd42;  7'd99: v = 8'd41;
            7'd100: v = 8'd40; 7'd101: v = 8'd39; 7'd102: v = 8'd38; 7'd103: v = 8'd36;
            7'd104: v = 8'd35; 7'd105: v = 8'd34; 7'd106: v = 8'd32; 7'd107: v = 8'd31;
            7'd108: v = 8'd30; 7'd109: v = 8'd28; 7'd110: v = 8'd27; 7'd111: v = 8'd26;
            7'd112: v = 8'd24; 7'd113: v = 8'd23; 7'd114: v = 8'd21; 7'd115: v = 8'd20;
            7'd116: v = 8'd18; 7'd117: v = 8'd17; 7'd118: v = 8'd15; 7'd119: v = 8'd14;
            7'd120: v = 8'd12; 7'd121: v = 8'd11; 7'd122: v = 8'd9;  7'd123: v = 8'd8;
            7'd124: v = 8'd6;  7'd125: v = 8'd5;  7'd126: v = 8'd3;  default: v = 8'd2;
        endcase
        return v;
    endfunction

    // square ROM, roughly n*n/256
    function automatic logic [7:0] square_rom(input logic [6:0] a);
        logic [7:0] v;
        case (a)
            7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
            7'd8, 7'd9, 7'd10, 7'd11, 7'd12, 7'd13, 7'd14: v = 8'd0;
            7'd15, 7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21: v = 8'd1;
            7'd22, 7'd23, 7'd24, 7'd25, 7'd26: v = 8'd2;
            7'd27, 7'd28, 7'd29, 7'd30: v = 8'd3;
            7'd31, 7'd32, 7'd33, 7'd34: v = 8'd4;
            7'd35, 7'd36, 7'd37, 7'd38: v = 8'd5;
            7'd39, 7'd40, 7'd41: v = 8'd6;
            7'd42, 7'd43, 7'd44: v = 8'd7;
            7'd45, 7'd46: v = 8'd8;
            7'd47, 7'd48, 7'd49: v = 8'd9;
            7'd50, 7'd51, 7'd52: v = 8'd10;
            7'd53, 7'd54: v = 8'd11;
            7'd55, 7'd56: v = 8'd12;
            7'd57, 7'd58: v = 8'd13;
            7'd59, 7'd60: v = 8'd14;
            7'd61, 7'd62: v = 8'd15;
            7'd63, 7'd64: v = 8'd16;
            7'd65, 7'd66: v = 8'd17;
            7'd67, 7'd68: v = 8'd18;
            7'd69, 7'd70: v = 8'd19;
            7'd71, 7'd72: v = 8'd20;
            7'd73, 7'd74: v = 8'd21;
            7'd75: v = 8'd22;
            7'd76, 7'd77: v = 8'd23;
            7'd78: v = 8'd24;
            7'd79, 7'd80: v = 8'd25;
            7'd81, 7'd82: v = 8'd26;
            7'd83: v = 8'd27;
            7'd84, 7'd85: v = 8'd28;
            7'd86: v = 8'd29;
            7'd87, 7'd88: v = 8'd30;
            7'd89: v = 8'd31;
            7'd90: v = 8'd32;
            7'd91, 7'd92: v = 8'd33;
            7'd93: v = 8'd34;
            7'd94: v = 8'd35;
            7'd95, 7'd96: v = 8'd36;
            7'd97: v = 8'd37;
            7'd98: v = 8'd38;
            7'd99, 7'd100: v = 8'd39;
            7'd101: v = 8'd40;
            7'd102: v = 8'd41;
            7'd103: v = 8'd42;
            7'd104, 7'd105: v = 8'd43;
            7'd106: v = 8'd44;
            7'd107: v = 8'd45;
            7'd108: v = 8'd46;
            7'd109: v = 8'd47;
            7'd110: v = 8'd48;
            7'd111, 7'd112: v = 8'd49;
            7'd113: v = 8'd50;
            7'd114: v = 8'd51;
            7'd115: v = 8'd52;
            7'd116: v = 8'd53;
            7'd117: v = 8'd54;
            7'd118: v = 8'd55;
            7'd119: v = 8'd56;
            7'd120: v = 8'd57;
            7'd121: v = 8'd58;
            7'd122: v = 8'd59;
            7'd123: v = 8'd60;
            7'd124: v = 8'd61;
            7'd125: v = 8'd62;
            7'd126: v = 8'd63;
            default: v = 8'd64;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] sin_byte(input logic [7:0] a);
        logic [7:0] h;
        h = sine_half(a[6:0]);
        return a[7] ? 8'(8'd0 - h) : h;
    endfunction

    function automatic logic [7:0] cos_byte(input logic [7:0] a);
        return sin_byte(8'(a + 8'd64));
    endfunction

    // byte absolute, 0x80 maps to 127
    function automatic logic [6:0] abs_byte(input logic [7:0] v);
        logic [7:0] n;
        n = 8'(8'd0 - v);
        if (!v[7]) return v[6:0];
        if (v == 8'h80) return 7'd127;
        return n[6:0];
    endfunction

endpackage
`default_nettype wire

FILE: design/vrsu_lane.sv
// vrsu_lane: one quarter-square product lane, combinational table lookups, registered product.
// Depends on vrsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrsu_lane (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire logic [7:0] a,
    input  wire logic [7:0] b,
    output logic [7:0]      prod
);
    logic [7:0] sq_p, sq_m;
    always_comb begin
        sq_p = vrsu_pkg::square_rom(vrsu_pkg::abs_byte(8'(a + b)));
        sq_m = vrsu_pkg::square_rom(vrsu_pkg::abs_byte(8'(a - b)));
    end

    // product registered once per stage advance
    always_ff @(posedge aclk) begin
        if (en) begin
            prod <= 8'(sq_p - sq_m);
        end
    end
endmodule
`default_nettype wire

FILE: design/vrsu_rot_stage.sv
// vrsu_rot_stage: one pipelined rotation step over a coordinate pair using
// four product lanes and a merge of the lane products. Depends on vrsu_pkg, vrsu_lane.
`timescale 1ns / 1ps
`default_nettype none
module vrsu_rot_stage (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire vrsu_pkg::rot_ctl_t ctl,
    input  wire logic [7:0]        u_in,
    input  wire logic [7:0]        v_in,
    output logic [7:0]             u_out,
    output logic [7:0]             v_out
);
    logic [7:0] c, s;
    logic [7:0] p_uc, p_vs, p_us, p_vc;
    logic [7:0] u_hold, v_hold;
    logic       rot_d;

    always_comb begin
        c = vrsu_pkg::cos_byte(ctl.ang);
        s = vrsu_pkg::sin_byte(ctl.ang);
    end

    vrsu_lane u_l0 (.aclk(aclk), .en(en), .a(u_in), .b(c), .prod(p_uc));
    vrsu_lane u_l1 (.aclk(aclk), .en(en), .a(v_in), .b(s), .prod(p_vs));
    vrsu_lane u_l2 (.aclk(aclk), .en(en), .a(u_in), .b(s), .prod(p_us));
    vrsu_lane u_l3 (.aclk(aclk), .en(en), .a(v_in), .b(c), .prod(p_vc));

    // passthrough copy for disabled steps
    always_ff @(posedge aclk) begin
        if (en) begin
            u_hold <= u_in;
            v_hold <= v_in;
            rot_d  <= ctl.en;
        end
    end

    // merge: difference and sum of lane products
    always_comb begin
        u_out = rot_d ? 8'(p_uc - p_vs) : u_hold;
        v_out = rot_d ? 8'(p_us + p_vc) : v_hold;
    end
endmodule
`default_nettype wire

FILE: design/vertex_rotate_scale_unit.sv
// vertex_rotate_scale_unit: top level, three rotation stages plus scale lanes.
// Depends on vrsu_pkg, vrsu_rot_stage, vrsu_lane.
//
// Usage:
//   Slave channel s_axis_* carries one vertex and its controls per beat; master
//   channel m_axis_* returns the transformed vertex, one beat per input beat.
//   Throughput is one vertex per cycle while m_axis_tready does not stall the
//   output; the three-stage product pipeline (Y step, X step, Z step, each
//   four table lanes) registers the products of every step.
//   Stage 1 rotates about Y (or the single axis, or scales), stage 2 about X,
//   stage 3 about Z. Unused steps pass the pair through.
//   The whole pipeline advances together; when m_axis_tready is low and the
//   last stage holds a beat, every stage freezes and s_axis_tready drops,
//   even if earlier stages hold bubbles.
//   Reset (aresetn low, synchronous) empties all stages; data is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module vertex_rotate_scale_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[2:0], in_x[10:3], in_y[18:11], in_z[26:19], angle_a[34:27],
    // angle_b[42:35], angle_c[50:43], scale_factor[58:51], zero fill to 64
    input  wire logic [63:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_x[7:0], out_y[15:8], out_z[23:16]
    output logic [23:0]      m_axis_tdata
);
    vrsu_pkg::action_t act;
    logic [7:0] x0, y0, z0, aa, ab, ac, sf;
    logic       adv;
    logic [2:0] vld_reg;

    assign act = vrsu_pkg::action_t'(s_axis_tdata[2:0]);
    assign x0  = s_axis_tdata[10:3];
    assign y0  = s_axis_tdata[18:11];
    assign z0  = s_axis_tdata[26:19];
    assign aa  = s_axis_tdata[34:27];
    assign ab  = s_axis_tdata[42:35];
    assign ac  = s_axis_tdata[50:43];
    assign sf  = s_axis_tdata[58:51];

    // whole pipeline moves when the output slot is free or empty
    assign adv           = !vld_reg[2] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 3'b000;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], s_axis_tvalid};
        end
    end

    // stage 1 step selection: pair (u,v) and angle
    vrsu_pkg::rot_ctl_t ctl1;
    logic [7:0] u1, v1, u1o, v1o;
    logic [1:0] sel1;        // 0 pair yz, 1 pair xz, 2 pair xy
    logic       scl1;
    always_comb begin
        ctl1 = '{en: 1'b1, ang: aa};
        sel1 = 2'd1;
        scl1 = 1'b0;
        case (act)
            vrsu_pkg::ACT_ROT_X: sel1 = 2'd0;
            vrsu_pkg::ACT_ROT_Y: sel1 = 2'd1;
            vrsu_pkg::ACT_ROT_Z: sel1 = 2'd2;
            vrsu_pkg::ACT_ROT_YX, vrsu_pkg::ACT_ROT_YXZ: ctl1.ang = ab;
            vrsu_pkg::ACT_SCALE: begin
                ctl1.en = 1'b0;
                scl1    = 1'b1;
            end
            default: ctl1.en = 1'b0;
        endcase
        u1 = (sel1 == 2'd0) ? y0 : x0;
        v1 = (sel1 == 2'd2) ? y0 : z0;
    end

    vrsu_rot_stage u_st1 (.aclk(aclk), .en(adv), .ctl(ctl1),
                          .u_in(u1), .v_in(v1), .u_out(u1o), .v_out(v1o));

    // scale lanes, one per coordinate, separate from the pair lanes
    logic [7:0] sx, sy, sz;
    vrsu_lane u_sx (.aclk(aclk), .en(adv), .a(x0), .b(sf), .prod(sx));
    vrsu_lane u_sy (.aclk(aclk), .en(adv), .a(y0), .b(sf), .prod(sy));
    vrsu_lane u_sz (.aclk(aclk), .en(adv), .a(z0), .b(sf), .prod(sz));

    // stage 1 side registers
    logic [7:0] x1_reg, y1_reg, z1_reg, aa1_reg, ac1_reg;
    logic [1:0] sel1_reg;
    logic       scl1_reg;
    vrsu_pkg::action_t act1_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg   <= x0;
            y1_reg   <= y0;
            z1_reg   <= z0;
            aa1_reg  <= aa;
            ac1_reg  <= ac;
            sel1_reg <= sel1;
            scl1_reg <= scl1;
            act1_reg <= act;
        end
    end

    // merge stage 1 into a full vertex
    logic [7:0] x1, y1, z1;
    always_comb begin
        x1 = x1_reg;
        y1 = y1_reg;
        z1 = z1_reg;
        if (scl1_reg) begin
            x1 = sx;
            y1 = sy;
            z1 = sz;
        end else begin
            case (sel1_reg)
                2'd0: begin y1 = u1o; z1 = v1o; end
                2'd2: begin x1 = u1o; y1 = v1o; end
                default: begin x1 = u1o; z1 = v1o; end
            endcase
        end
    end

    // stage 2: x-axis step on (y, z')
    vrsu_pkg::rot_ctl_t ctl2;
    logic [7:0] y2o, z2o;
    assign ctl2 = '{en: (act1_reg == vrsu_pkg::ACT_ROT_YX) ||
                        (act1_reg == vrsu_pkg::ACT_ROT_YXZ), ang: aa1_reg};
    vrsu_rot_stage u_st2 (.aclk(aclk), .en(adv), .ctl(ctl2),
                          .u_in(y1), .v_in(z1), .u_out(y2o), .v_out(z2o));

    logic [7:0] x2_reg, ac2_reg;
    logic       z3en_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg   <= x1;
            ac2_reg  <= ac1_reg;
            z3en_reg <= (act1_reg == vrsu_pkg::ACT_ROT_YXZ);
        end
    end

    // stage 3: z-axis step on (x', y')
    vrsu_pkg::rot_ctl_t ctl3;
    logic [7:0] x3o, y3o;
    assign ctl3 = '{en: z3en_reg, ang: ac2_reg};
    vrsu_rot_stage u_st3 (.aclk(aclk), .en(adv), .ctl(ctl3),
                          .u_in(x2_reg), .v_in(y2o), .u_out(x3o), .v_out(y3o));

    logic [7:0] z3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            z3_reg <= z2o;
        end
    end

    assign m_axis_tdata = {z3_reg, y3o, x3o};

    // a stalled output beat keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    // input ready follows the output slot
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output slot");
    // an accepted input reaches the output while the pipeline keeps advancing
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("beat lost in pipeline");
endmodule
`default_nettype wire
